// ----- rtl/cts_pkg.sv -----
// Shared types, codes and the control program of the conditional table sampler.
`default_nettype none

package cts_pkg;

    // Defaults of the top-level parameters.
    localparam int MAX_STATES_DEF  = 16;
    localparam int MAX_ARGS_DEF    = 4;
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int WEIGHT_BITS_DEF = 16;

    // Fixed field and register widths.
    localparam int NS_W       = 5;
    localparam int AC_W       = 3;
    localparam int COND_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;
    // Mixed-radix index accumulator: 31^5 stays below 2^25.
    localparam int ACC_W      = 26;
    localparam int K_W        = 5;

    // Operation codes.
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_DRAW  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    // Error codes.
    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_RANGE = 2'd1;
    localparam logic [1:0] ERR_ZERO  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_STATES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ARG_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_0      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_1      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_2      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_3      = 3'd5;

    // Command and response beats.
    typedef struct packed {
        t_op         op;
        logic [3:0]  state_index;
        logic [3:0]  cond_0;
        logic [3:0]  cond_1;
        logic [3:0]  cond_2;
        logic [3:0]  cond_3;
        logic [15:0] weight;
        logic [15:0] uniform;
    } t_cmd;

    typedef struct packed {
        logic [15:0] read_weight;
        logic [3:0]  sampled_state;
        logic [1:0]  error;
    } t_rsp;

    // Datapath actions selected by the control word.
    typedef enum logic [3:0] {
        ACT_NONE     = 4'd0,
        ACT_LOAD     = 4'd1,
        ACT_CFGCHK   = 4'd2,
        ACT_ARG      = 4'd3,
        ACT_RANGE    = 4'd4,
        ACT_WRITE    = 4'd5,
        ACT_RDADDR   = 4'd6,
        ACT_RDCAP    = 4'd7,
        ACT_SUMINIT  = 4'd8,
        ACT_SUM      = 4'd9,
        ACT_MUL      = 4'd10,
        ACT_SEARCH   = 4'd11,
        ACT_CLAMP    = 4'd12,
        ACT_ZEROERR  = 4'd13,
        ACT_DONE     = 4'd14
    } t_act;

    // Jump conditions.
    typedef enum logic [3:0] {
        C_NEVER      = 4'd0,
        C_ALWAYS     = 4'd1,
        C_NOT_START  = 4'd2,
        C_OP_NOP     = 4'd3,
        C_ERR        = 4'd4,
        C_ARG_DONE   = 4'd5,
        C_OP_READ    = 4'd6,
        C_OP_DRAW    = 4'd7,
        C_LOOP_BUSY  = 4'd8,
        C_TOTAL_ZERO = 4'd9
    } t_cond;

    typedef logic [4:0] t_pc;

    // Program step labels.
    localparam t_pc PC_WAIT      = 5'd0;
    localparam t_pc PC_NOP_CHK   = 5'd1;
    localparam t_pc PC_CFG_CHK   = 5'd2;
    localparam t_pc PC_CFG_ERR   = 5'd3;
    localparam t_pc PC_ARG_TEST  = 5'd4;
    localparam t_pc PC_ARG_STEP  = 5'd5;
    localparam t_pc PC_RANGE     = 5'd6;
    localparam t_pc PC_RANGE_ERR = 5'd7;
    localparam t_pc PC_DISP_RD   = 5'd8;
    localparam t_pc PC_DISP_DRAW = 5'd9;
    localparam t_pc PC_WRITE     = 5'd10;
    localparam t_pc PC_RD_ADDR   = 5'd11;
    localparam t_pc PC_RD_CAP    = 5'd12;
    localparam t_pc PC_SUM_INIT  = 5'd13;
    localparam t_pc PC_SUM       = 5'd14;
    localparam t_pc PC_ZERO_CHK  = 5'd15;
    localparam t_pc PC_MUL       = 5'd16;
    localparam t_pc PC_SEARCH    = 5'd17;
    localparam t_pc PC_CLAMP     = 5'd18;
    localparam t_pc PC_ZERO_ERR  = 5'd19;
    localparam t_pc PC_FIN       = 5'd20;

    typedef struct packed {
        t_act  act;
        t_cond cond;
        t_pc   target;
    } t_ctrl;

    // Status from the datapath that the jump conditions test.
    typedef struct packed {
        logic err;
        logic arg_done;
        logic loop_busy;
        logic total_zero;
        t_op  op;
    } t_flags;

    // Control store: one word per step. A true condition jumps to target,
    // otherwise the step counter advances by one.
    function automatic t_ctrl ucode(input t_pc pc);
        t_ctrl w;
        w = '{act: ACT_NONE, cond: C_ALWAYS, target: PC_WAIT};
        case (pc)
            PC_WAIT:      w = '{act: ACT_LOAD,    cond: C_NOT_START,  target: PC_WAIT};
            PC_NOP_CHK:   w = '{act: ACT_NONE,    cond: C_OP_NOP,     target: PC_FIN};
            PC_CFG_CHK:   w = '{act: ACT_CFGCHK,  cond: C_NEVER,      target: PC_WAIT};
            PC_CFG_ERR:   w = '{act: ACT_NONE,    cond: C_ERR,        target: PC_FIN};
            PC_ARG_TEST:  w = '{act: ACT_NONE,    cond: C_ARG_DONE,   target: PC_RANGE};
            PC_ARG_STEP:  w = '{act: ACT_ARG,     cond: C_ALWAYS,     target: PC_ARG_TEST};
            PC_RANGE:     w = '{act: ACT_RANGE,   cond: C_NEVER,      target: PC_WAIT};
            PC_RANGE_ERR: w = '{act: ACT_NONE,    cond: C_ERR,        target: PC_FIN};
            PC_DISP_RD:   w = '{act: ACT_NONE,    cond: C_OP_READ,    target: PC_RD_ADDR};
            PC_DISP_DRAW: w = '{act: ACT_NONE,    cond: C_OP_DRAW,    target: PC_SUM_INIT};
            PC_WRITE:     w = '{act: ACT_WRITE,   cond: C_ALWAYS,     target: PC_FIN};
            PC_RD_ADDR:   w = '{act: ACT_RDADDR,  cond: C_NEVER,      target: PC_WAIT};
            PC_RD_CAP:    w = '{act: ACT_RDCAP,   cond: C_ALWAYS,     target: PC_FIN};
            PC_SUM_INIT:  w = '{act: ACT_SUMINIT, cond: C_NEVER,      target: PC_WAIT};
            PC_SUM:       w = '{act: ACT_SUM,     cond: C_LOOP_BUSY,  target: PC_SUM};
            PC_ZERO_CHK:  w = '{act: ACT_NONE,    cond: C_TOTAL_ZERO, target: PC_ZERO_ERR};
            PC_MUL:       w = '{act: ACT_MUL,     cond: C_NEVER,      target: PC_WAIT};
            PC_SEARCH:    w = '{act: ACT_SEARCH,  cond: C_LOOP_BUSY,  target: PC_SEARCH};
            PC_CLAMP:     w = '{act: ACT_CLAMP,   cond: C_ALWAYS,     target: PC_FIN};
            PC_ZERO_ERR:  w = '{act: ACT_ZEROERR, cond: C_ALWAYS,     target: PC_FIN};
            PC_FIN:       w = '{act: ACT_DONE,    cond: C_ALWAYS,     target: PC_WAIT};
            default:      w = '{act: ACT_NONE,    cond: C_ALWAYS,     target: PC_WAIT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/cts_seq.sv -----
// Step counter and jump logic that walks the control store.
`default_nettype none

module cts_seq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire cts_pkg::t_flags i_flags,
    output cts_pkg::t_act        o_act,
    output logic                 o_busy
);
    import cts_pkg::*;

    t_pc   r_pc;
    t_pc   n_pc;
    t_ctrl w_ctrl;
    logic  w_take;

    // Fetch the control word of the current step.
    assign w_ctrl = ucode(r_pc);
    assign o_act  = w_ctrl.act;
    assign o_busy = (r_pc != PC_WAIT);

    // Evaluate the jump condition.
    always_comb begin
        unique case (w_ctrl.cond)
            C_NEVER:      w_take = 1'b0;
            C_ALWAYS:     w_take = 1'b1;
            C_NOT_START:  w_take = !i_start;
            C_OP_NOP:     w_take = (i_flags.op == OP_NOP);
            C_ERR:        w_take = i_flags.err;
            C_ARG_DONE:   w_take = i_flags.arg_done;
            C_OP_READ:    w_take = (i_flags.op == OP_READ);
            C_OP_DRAW:    w_take = (i_flags.op == OP_DRAW);
            C_LOOP_BUSY:  w_take = i_flags.loop_busy;
            C_TOTAL_ZERO: w_take = i_flags.total_zero;
            default:      w_take = 1'b1;
        endcase
        n_pc = w_take ? w_ctrl.target : t_pc'(r_pc + 5'd1);
    end

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/cts_wram.sv -----
// Weight table memory with one write port and one registered read port.
`default_nettype none

module cts_wram #(
    parameter int DEPTH = cts_pkg::TABLE_DEPTH_DEF,
    parameter int WIDTH = cts_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);
    import cts_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/cts_datapath.sv -----
// Configuration registers, index arithmetic, row accumulation and the draw compare.
`default_nettype none

module cts_datapath #(
    parameter int MAX_STATES  = cts_pkg::MAX_STATES_DEF,
    parameter int MAX_ARGS    = cts_pkg::MAX_ARGS_DEF,
    parameter int TABLE_DEPTH = cts_pkg::TABLE_DEPTH_DEF,
    parameter int WEIGHT_BITS = cts_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire cts_pkg::t_act                 i_act,
    input  wire logic                          i_start,
    input  wire cts_pkg::t_cmd                 i_cmd,
    input  wire logic                          i_cfg_we,
    input  wire logic [cts_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [cts_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output cts_pkg::t_flags                    o_flags,
    output logic                               o_done,
    output cts_pkg::t_rsp                      o_rsp
);
    import cts_pkg::*;

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int TOT_W = WEIGHT_BITS + NS_W;
    localparam int TGT_W = TOT_W + 16;

    // Configuration registers.
    logic [NS_W-1:0] r_num_states;
    logic [AC_W-1:0] r_arg_count;
    logic [NS_W-1:0] r_dim [4];

    // Working registers of one item.
    t_cmd             r_cmd;
    logic [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] r_stride;
    logic [AC_W-1:0]  r_a;
    logic [1:0]       r_err;
    logic [15:0]      r_rd;
    logic [3:0]       r_smp;
    logic [K_W-1:0]   r_k;
    logic             r_rv;
    logic [TOT_W-1:0] r_total;
    logic [TOT_W-1:0] r_cum;
    logic [TGT_W-1:0] r_target;
    logic             r_found;
    logic             r_done;
    t_rsp             r_rsp;

    logic [COND_W-1:0]    w_cond [4];
    logic [COND_W-1:0]    w_c;
    logic [NS_W-1:0]      w_d;
    logic [ACC_W-1:0]     w_row_addr;
    logic [ACC_W:0]       w_end;
    logic                 w_issue;
    logic                 w_ram_re;
    logic                 w_ram_we;
    logic [AW-1:0]        w_raddr;
    logic [WEIGHT_BITS-1:0] w_rdata;
    logic [TOT_W-1:0]     w_cum_n;
    logic                 w_hit;

    // Configuration write port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_states <= 5'd16;
            r_arg_count  <= 3'd0;
            r_dim[0]     <= 5'd1;
            r_dim[1]     <= 5'd1;
            r_dim[2]     <= 5'd1;
            r_dim[3]     <= 5'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NUM_STATES: r_num_states <= i_cfg_data;
                CFG_ARG_COUNT:  r_arg_count  <= i_cfg_data[AC_W-1:0];
                CFG_DIM_0:      r_dim[0]     <= i_cfg_data;
                CFG_DIM_1:      r_dim[1]     <= i_cfg_data;
                CFG_DIM_2:      r_dim[2]     <= i_cfg_data;
                CFG_DIM_3:      r_dim[3]     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Operand selection for the argument step and row addressing.
    assign w_cond[0]  = r_cmd.cond_0;
    assign w_cond[1]  = r_cmd.cond_1;
    assign w_cond[2]  = r_cmd.cond_2;
    assign w_cond[3]  = r_cmd.cond_3;
    assign w_c        = w_cond[r_a[1:0]];
    assign w_d        = r_dim[r_a[1:0]];
    assign w_row_addr = r_acc + ACC_W'(r_k);
    assign w_end      = (ACC_W+1)'(r_acc) + (ACC_W+1)'(r_num_states);

    // Memory port control: the row loops issue one read per cycle.
    assign w_issue  = ((i_act == ACT_SUM) || (i_act == ACT_SEARCH)) && (r_k < r_num_states);
    assign w_ram_re = w_issue || (i_act == ACT_RDADDR);
    assign w_ram_we = (i_act == ACT_WRITE);
    assign w_raddr  = (i_act == ACT_RDADDR) ? r_acc[AW-1:0] : w_row_addr[AW-1:0];

    cts_wram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (WEIGHT_BITS)
    ) u_wram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_acc[AW-1:0]),
        .i_wdata (WEIGHT_BITS'(r_cmd.weight)),
        .i_re    (w_ram_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Cumulative weight and the unnormalized draw compare.
    assign w_cum_n = r_cum + TOT_W'(w_rdata);
    assign w_hit   = (r_target <= {w_cum_n, 16'd0});

    // Datapath actions.
    always_ff @(posedge i_clk) begin
        unique case (i_act)
            ACT_LOAD: begin
                if (i_start) begin
                    r_cmd    <= i_cmd;
                    r_acc    <= (i_cmd.op == OP_DRAW) ? '0 : ACC_W'(i_cmd.state_index);
                    r_stride <= ACC_W'(r_num_states);
                    r_a      <= '0;
                    r_err    <= ERR_OK;
                    r_rd     <= '0;
                    r_smp    <= '0;
                end
            end
            ACT_CFGCHK: begin
                if ((r_num_states == '0) || (int'(r_num_states) > MAX_STATES)
                    || (int'(r_arg_count) > MAX_ARGS)) begin
                    r_err <= ERR_RANGE;
                end
            end
            ACT_ARG: begin
                if ({1'b0, w_c} >= w_d) begin
                    r_err <= ERR_RANGE;
                end
                r_acc    <= r_acc + ACC_W'(w_c * r_stride);
                r_stride <= ACC_W'(r_stride * w_d);
                r_a      <= r_a + 3'd1;
            end
            ACT_RANGE: begin
                if (r_cmd.op == OP_DRAW) begin
                    if ((r_acc >= ACC_W'(TABLE_DEPTH)) || (w_end > (ACC_W+1)'(TABLE_DEPTH))) begin
                        r_err <= ERR_RANGE;
                    end
                end else if (({1'b0, r_cmd.state_index} >= r_num_states)
                             || (r_acc >= ACC_W'(TABLE_DEPTH))) begin
                    r_err <= ERR_RANGE;
                end
            end
            ACT_RDCAP: begin
                r_rd <= 16'(w_rdata);
            end
            ACT_SUMINIT: begin
                r_k     <= '0;
                r_rv    <= 1'b0;
                r_total <= '0;
            end
            ACT_SUM: begin
                if (r_rv) begin
                    r_total <= r_total + TOT_W'(w_rdata);
                end
                if (w_issue) begin
                    r_k <= r_k + 5'd1;
                end
                r_rv <= w_issue;
            end
            ACT_MUL: begin
                r_target <= TGT_W'(r_cmd.uniform) * TGT_W'(r_total);
                r_k      <= '0;
                r_rv     <= 1'b0;
                r_cum    <= '0;
                r_found  <= 1'b0;
            end
            ACT_SEARCH: begin
                // The data in hand belongs to the state one below the read count.
                if (r_rv) begin
                    r_cum <= w_cum_n;
                    if (!r_found && w_hit) begin
                        r_found <= 1'b1;
                        r_smp   <= 4'(r_k - 5'd1);
                    end
                end
                if (w_issue) begin
                    r_k <= r_k + 5'd1;
                end
                r_rv <= w_issue;
            end
            ACT_CLAMP: begin
                if (!r_found) begin
                    r_smp <= 4'(r_num_states - 5'd1);
                end
            end
            ACT_ZEROERR: begin
                r_err <= ERR_ZERO;
            end
            ACT_DONE: begin
                r_rsp.read_weight   <= (r_err == ERR_OK) ? r_rd : '0;
                r_rsp.sampled_state <= (r_err == ERR_OK) ? r_smp : '0;
                r_rsp.error         <= r_err;
            end
            default: begin
            end
        endcase
    end

    // Result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (i_act == ACT_DONE);
        end
    end

    // Status back to the sequencer.
    assign o_flags.err        = (r_err != ERR_OK);
    assign o_flags.arg_done   = (r_a >= r_arg_count);
    assign o_flags.loop_busy  = (r_k < r_num_states) || r_rv;
    assign o_flags.total_zero = (r_total == '0);
    assign o_flags.op         = r_cmd.op;
    assign o_done             = r_done;
    assign o_rsp              = r_rsp;

    // A write reaches the table only after all index checks passed.
    a_write_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> (r_err == ERR_OK))
        else $error("table write with an index error pending");

    // Row reads stay inside the table.
    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_issue |-> (w_row_addr < ACC_W'(TABLE_DEPTH)))
        else $error("row read beyond the table");

    // Once the draw has found its state, later weights do not move it.
    a_first_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((i_act == ACT_SEARCH) && r_found) |=> $stable(r_smp))
        else $error("drawn state changed after the first hit");

endmodule

`default_nettype wire

// ----- rtl/conditional_table_sampler_unit.sv -----
// Top level of the conditional table sampler: sequencer, datapath and weight table.
// A draw walks its row twice through the single read port of the table, one weight a cycle.
// Busy drops with the strobe and the next beat is taken at the edge that ends it; the receiver
// cannot stall. Reset is synchronous, active low.
`default_nettype none

module conditional_table_sampler_unit #(
    parameter int MAX_STATES  = cts_pkg::MAX_STATES_DEF,
    parameter int MAX_ARGS    = cts_pkg::MAX_ARGS_DEF,
    parameter int TABLE_DEPTH = cts_pkg::TABLE_DEPTH_DEF,
    parameter int WEIGHT_BITS = cts_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    output logic                                o_busy,
    input  wire cts_pkg::t_cmd                  i_cmd,
    output logic                                o_done,
    output cts_pkg::t_rsp                       o_rsp,
    input  wire logic                           i_cfg_we,
    input  wire logic [cts_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [cts_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import cts_pkg::*;

    t_act   w_act;
    t_flags w_flags;

    // Control sequencer.
    cts_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_flags (w_flags),
        .o_act   (w_act),
        .o_busy  (o_busy)
    );

    // Datapath with the weight table.
    cts_datapath #(
        .MAX_STATES  (MAX_STATES),
        .MAX_ARGS    (MAX_ARGS),
        .TABLE_DEPTH (TABLE_DEPTH),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_act      (w_act),
        .i_start    (i_start),
        .i_cmd      (i_cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_flags    (w_flags),
        .o_done     (o_done),
        .o_rsp      (o_rsp)
    );

    // A result beat lasts one cycle.
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // An accepted command keeps the block busy.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("block not busy after accepting a command");

    // A failed item returns zero data.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.error != ERR_OK))
        |-> ((o_rsp.read_weight == '0) && (o_rsp.sampled_state == '0)))
        else $error("nonzero data with an error code");

endmodule

`default_nettype wire

// ----- tb/conditional_table_sampler_checker.sv -----
// Checker of the conditional table sampler: predicts every command beat and compares results.
`timescale 1ns / 100ps

module conditional_table_sampler_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic                           i_busy,
    input  wire cts_pkg::t_cmd                  i_cmd,
    input  wire logic                           i_done,
    input  wire cts_pkg::t_rsp                  i_rsp,
    input  wire logic                           i_cfg_we,
    input  wire logic [cts_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [cts_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import cts_pkg::*;

    localparam int DEPTH      = TABLE_DEPTH_DEF;
    localparam int STATES_MAX = MAX_STATES_DEF;
    localparam int ARGS_MAX   = MAX_ARGS_DEF;

    // Mirror of the weight table and of the settings registers.
    logic [15:0] weight_mem [DEPTH];
    logic [4:0]  n_states;
    logic [2:0]  n_args;
    logic [4:0]  dim [4];

    // Results still owed by the block, oldest first.
    t_rsp owed_q [$];

    // Mixed-radix position of one entry; zero when the settings or a condition are out of range.
    function automatic bit locate(input t_cmd c, input int unsigned st,
                                  output longint unsigned addr);
        longint unsigned acc;
        longint unsigned stride;
        logic [3:0]      cv [4];
        cv[0] = c.cond_0;
        cv[1] = c.cond_1;
        cv[2] = c.cond_2;
        cv[3] = c.cond_3;
        addr  = 0;
        if (n_states == 0 || n_states > STATES_MAX || n_args > ARGS_MAX) return 1'b0;
        acc    = st;
        stride = n_states;
        for (int a = 0; a < n_args; a++) begin
            if (cv[a] >= dim[a]) return 1'b0;
            acc    += cv[a] * stride;
            stride *= dim[a];
        end
        addr = acc;
        return 1'b1;
    endfunction

    // Result of one command; a write also updates the mirrored table.
    function automatic t_rsp predict(input t_cmd c);
        t_rsp            r;
        longint unsigned addr;
        longint unsigned total;
        longint unsigned cum;
        longint unsigned target;
        int unsigned     sel;
        bit              found;
        r = '0;
        if (c.op == OP_WRITE || c.op == OP_READ) begin
            if (c.state_index >= n_states || !locate(c, c.state_index, addr)
                || addr >= DEPTH) begin
                r.error = ERR_RANGE;
            end else if (c.op == OP_WRITE) begin
                weight_mem[addr] = c.weight;
            end else begin
                r.read_weight = weight_mem[addr];
            end
        end else if (c.op == OP_DRAW) begin
            if (!locate(c, 0, addr) || addr + n_states > DEPTH) begin
                r.error = ERR_RANGE;
            end else begin
                total = 0;
                for (int k = 0; k < n_states; k++) total += weight_mem[addr + k];
                if (total == 0) begin
                    r.error = ERR_ZERO;
                end else begin
                    // First state whose cumulative weight covers u times the row total.
                    target = c.uniform * total;
                    cum    = 0;
                    found  = 1'b0;
                    sel    = n_states - 1;
                    for (int k = 0; k < n_states; k++) begin
                        cum += weight_mem[addr + k];
                        if (!found && target <= (cum << 16)) begin
                            found = 1'b1;
                            sel   = k;
                        end
                    end
                    r.sampled_state = sel[3:0];
                end
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    // Results are compared before a new command is taken, since both can share an edge.
    always @(posedge i_clk) begin : watch
        t_rsp want;
        if (!i_rst_n) begin
            n_states     = 5'd16;
            n_args       = 3'd0;
            dim[0]       = 5'd1;
            dim[1]       = 5'd1;
            dim[2]       = 5'd1;
            dim[3]       = 5'd1;
            o_fail_count = 0;
            owed_q.delete();
        end else begin
            if (i_done) begin
                if (owed_q.size() == 0) begin
                    $error("result beat with no command outstanding");
                    o_fail_count++;
                end else begin
                    want = owed_q.pop_front();
                    check_field("read_weight", want.read_weight, i_rsp.read_weight);
                    check_field("sampled_state", want.sampled_state, i_rsp.sampled_state);
                    check_field("error", want.error, i_rsp.error);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_NUM_STATES: n_states = i_cfg_data;
                    CFG_ARG_COUNT:  n_args   = i_cfg_data[2:0];
                    CFG_DIM_0:      dim[0]   = i_cfg_data;
                    CFG_DIM_1:      dim[1]   = i_cfg_data;
                    CFG_DIM_2:      dim[2]   = i_cfg_data;
                    CFG_DIM_3:      dim[3]   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !i_busy) owed_q.push_back(predict(i_cmd));
        end
        o_pending = owed_q.size();
    end

endmodule

// ----- tb/conditional_table_sampler_unit_tb.sv -----
// Stimulus and verdict for the conditional table sampler, checked by a separate checker.
`timescale 1ns / 100ps

module conditional_table_sampler_unit_tb;
    import cts_pkg::*;

    localparam int NUM_PHASES = 12;
    localparam int PHASE_BEATS = 64;
    localparam int CMD_W = $bits(t_cmd);

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_start;
    logic                  o_busy;
    t_cmd                  i_cmd;
    logic                  o_done;
    t_rsp                  o_rsp;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int                    fail_count;
    int                    pending;

    // Settings as last written, used to aim conditions inside their ranges.
    int unsigned cur_states;
    int unsigned cur_args;
    int unsigned cur_dim [4];
    bit          idle_en;
    int          beats_sent;
    int          settings_used;

    conditional_table_sampler_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_cmd      (i_cmd),
        .o_done     (o_done),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    conditional_table_sampler_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_busy       (o_busy),
        .i_cmd        (i_cmd),
        .i_done       (o_done),
        .i_rsp        (o_rsp),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #12_000_000;
        $display("Verification failed");
        $finish;
    end

    // Random gaps may fall while the block is still busy with the previous beat.
    task automatic send_beat(input t_cmd c);
        @(negedge i_clk);
        while (idle_en && $urandom_range(99) < 26) begin
            i_start <= 1'b0;
            @(negedge i_clk);
        end
        i_start <= 1'b1;
        i_cmd   <= c;
        do @(posedge i_clk); while (o_busy);
        beats_sent++;
    endtask

    // Hold off until every result is in and the block has settled.
    task automatic drain();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic apply_setting(input int unsigned ns, input int unsigned ac,
                                 input int unsigned d0, input int unsigned d1,
                                 input int unsigned d2, input int unsigned d3);
        // Indexes past the last register must be ignored.
        write_reg(CFG_IDX_W'(CFG_DIM_3 + 1 + $urandom_range(1)), CFG_DATA_W'($urandom));
        write_reg(CFG_NUM_STATES, CFG_DATA_W'(ns));
        write_reg(CFG_ARG_COUNT, CFG_DATA_W'(ac));
        write_reg(CFG_DIM_0, CFG_DATA_W'(d0));
        write_reg(CFG_DIM_1, CFG_DATA_W'(d1));
        write_reg(CFG_DIM_2, CFG_DATA_W'(d2));
        write_reg(CFG_DIM_3, CFG_DATA_W'(d3));
        cur_states = ns;
        cur_args   = ac;
        cur_dim[0] = d0;
        cur_dim[1] = d1;
        cur_dim[2] = d2;
        cur_dim[3] = d3;
        settings_used++;
    endtask

    function automatic logic [15:0] pick_weight();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(15, 1));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_fraction();
        case ($urandom_range(5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(15));
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly in range for arguments in use, sometimes anything.
    function automatic logic [3:0] pick_cond(input int unsigned a);
        if (a < cur_args && cur_dim[a] >= 1 && cur_dim[a] <= 16 && $urandom_range(9) != 0)
            return 4'($urandom_range(cur_dim[a] - 1));
        return 4'($urandom_range(15));
    endfunction

    function automatic logic [3:0] pick_state();
        if (cur_states >= 1 && cur_states <= 16 && $urandom_range(9) != 0)
            return 4'($urandom_range(cur_states - 1));
        return 4'($urandom_range(15));
    endfunction

    function automatic t_cmd row_cmd();
        t_cmd c;
        c.op          = OP_DRAW;
        c.state_index = 4'($urandom);
        c.cond_0      = pick_cond(0);
        c.cond_1      = pick_cond(1);
        c.cond_2      = pick_cond(2);
        c.cond_3      = pick_cond(3);
        c.weight      = pick_weight();
        c.uniform     = pick_fraction();
        return c;
    endfunction

    // Command on the first two arguments; the other two carry random values.
    function automatic t_cmd cmd_at(input t_op op, input logic [3:0] st, input logic [3:0] c0,
                                    input logic [3:0] c1, input logic [15:0] w,
                                    input logic [15:0] u);
        t_cmd c;
        c.op          = op;
        c.state_index = st;
        c.cond_0      = c0;
        c.cond_1      = c1;
        c.cond_2      = 4'($urandom);
        c.cond_3      = 4'($urandom);
        c.weight      = w;
        c.uniform     = u;
        return c;
    endfunction

    // Optionally rewrite a whole row, sometimes to all zeros, then draw from it.
    task automatic row_sequence();
        t_cmd c;
        bit   zero_row;
        c = row_cmd();
        if (cur_states >= 1 && cur_states <= 16 && $urandom_range(2) == 0) begin
            zero_row = ($urandom_range(5) == 0);
            for (int s = 0; s < cur_states; s++) begin
                c.op          = OP_WRITE;
                c.state_index = 4'(s);
                c.weight      = zero_row ? 16'h0000 : pick_weight();
                send_beat(c);
            end
        end
        repeat ($urandom_range(3, 1)) begin
            c.op          = OP_DRAW;
            c.state_index = 4'($urandom);
            c.uniform     = pick_fraction();
            send_beat(c);
        end
    endtask

    task automatic choose_setting(input int phase);
        case (phase)
            0:       apply_setting(16, 0, 1, 1, 1, 1);
            1:       apply_setting(1, 4, 16, 16, 16, 16);
            2:       apply_setting(16, 4, 2, 2, 2, 4);
            3:       apply_setting(0, 2, 4, 4, 1, 1);
            4:       apply_setting($urandom_range(31, 17), 1, 16, 1, 1, 1);
            5:       apply_setting(8, $urandom_range(7, 5), 2, 2, 2, 2);
            6:       apply_setting(2, 2, $urandom_range(31, 17), 2, 0, 16);
            7:       apply_setting(16, 1, 16, 1, 1, 1);
            9:       apply_setting(4, 1, 0, 3, 3, 3);
            default: apply_setting($urandom_range(16, 1), $urandom_range(4),
                                   $urandom_range(16, 1), $urandom_range(16, 1),
                                   $urandom_range(16, 1), $urandom_range(16, 1));
        endcase
    endtask

    initial begin
        int   phase_start;
        int   pick;
        int   fill_beats;
        t_cmd c;
        i_rst_n       = 1'b0;
        i_start       = 1'b0;
        i_cmd         = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        idle_en       = 1'b1;
        beats_sent    = 0;
        settings_used = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Preload: 16 states x 16 x 4 rows covers every table entry exactly once.
        apply_setting(16, 2, 16, 4, 1, 1);
        for (int c1 = 0; c1 < 4; c1++)
            for (int c0 = 0; c0 < 16; c0++)
                for (int s = 0; s < 16; s++)
                    send_beat(cmd_at(OP_WRITE, 4'(s), 4'(c0), 4'(c1), pick_weight(), 16'h0));
        fill_beats = beats_sent;

        // Directed: field extremes, out-of-range conditions and the unused op code.
        send_beat(cmd_at(OP_WRITE, 4'hF, 4'hF, 4'd3, 16'hFFFF, 16'h0));
        send_beat(cmd_at(OP_READ, 4'hF, 4'hF, 4'd3, 16'h0, 16'h0));
        send_beat(cmd_at(OP_WRITE, 4'h0, 4'h0, 4'd0, 16'h0000, 16'hFFFF));
        send_beat(cmd_at(OP_READ, 4'h0, 4'h0, 4'd0, 16'hFFFF, 16'h0));
        send_beat(cmd_at(OP_DRAW, 4'h0, 4'h0, 4'd0, 16'h0, 16'h0000));
        send_beat(cmd_at(OP_DRAW, 4'hF, 4'hF, 4'd3, 16'h0, 16'hFFFF));
        send_beat(cmd_at(OP_WRITE, 4'h1, 4'h2, 4'd4, 16'h1234, 16'h0));
        send_beat(cmd_at(OP_READ, 4'h1, 4'h2, 4'd4, 16'h0, 16'h0));
        send_beat(cmd_at(OP_DRAW, 4'h1, 4'h2, 4'd4, 16'h0, 16'h8000));
        c = '1;
        send_beat(c);
        drain();

        // Two-state rows: zero total, a state index past the end, the smallest fractions.
        apply_setting(2, 2, 16, 4, 1, 1);
        send_beat(cmd_at(OP_WRITE, 4'h0, 4'h5, 4'd2, 16'h0000, 16'h0));
        send_beat(cmd_at(OP_WRITE, 4'h1, 4'h5, 4'd2, 16'h0000, 16'h0));
        send_beat(cmd_at(OP_DRAW, 4'h0, 4'h5, 4'd2, 16'h0, 16'h4000));
        send_beat(cmd_at(OP_READ, 4'h2, 4'h5, 4'd2, 16'h0, 16'h0));
        send_beat(cmd_at(OP_WRITE, 4'h3, 4'h5, 4'd2, 16'h0007, 16'h0));
        send_beat(cmd_at(OP_WRITE, 4'h1, 4'h5, 4'd2, 16'h0001, 16'h0));
        send_beat(cmd_at(OP_DRAW, 4'h0, 4'h5, 4'd2, 16'h0, 16'hFFFF));
        send_beat(cmd_at(OP_DRAW, 4'h0, 4'h5, 4'd2, 16'h0, 16'h0000));
        send_beat(cmd_at(OP_DRAW, 4'h0, 4'h5, 4'd2, 16'h0, 16'h0001));
        drain();

        // Random phases, each under its own settings; one runs without any gaps.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            choose_setting(phase);
            idle_en     = (phase != 2);
            phase_start = beats_sent;
            while (beats_sent - phase_start < PHASE_BEATS) begin
                pick = $urandom_range(99);
                if (pick < 45) begin
                    row_sequence();
                end else if (pick < 80) begin
                    c             = row_cmd();
                    c.op          = (pick < 65) ? OP_READ : OP_WRITE;
                    c.state_index = pick_state();
                    send_beat(c);
                end else begin
                    c = CMD_W'({$urandom, $urandom});
                    send_beat(c);
                end
            end
            drain();
        end
        repeat (80) @(negedge i_clk);

        $display("Ran %0d command beats (%0d of them preloading the table) under %0d settings.",
                 beats_sent, fill_beats, settings_used);
        $display("Covered reads, writes, draws, zero rows, bad indexes and illegal settings.");
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/cts_pkg.sv
rtl/cts_seq.sv
rtl/cts_wram.sv
rtl/cts_datapath.sv
rtl/conditional_table_sampler_unit.sv
tb/conditional_table_sampler_checker.sv
tb/conditional_table_sampler_unit_tb.sv
